// ===== rtl/avafd_pkg.sv =====
// Package for the axis-angle-from-Y block: widths, stage payload types and
// the CORDIC arctangent table. No dependencies.
`default_nettype none
package avafd_pkg;

    localparam int CW         = 16;
    localparam int DW         = CW + 1;
    localparam int MW         = CW;
    localparam int PW         = 2 * MW;
    localparam int SW         = PW + 2;
    localparam int RW         = 31;
    localparam int REMW       = RW + 4;
    localparam int SQ_STEPS   = 31;
    localparam int INT_FRAC   = 14;
    localparam int TAB_FRAC   = 16;
    localparam int ANGLE_FRAC = 8;
    localparam int AXIS_FRAC  = 14;
    localparam int ROT_STEPS  = 23;
    localparam int XW         = 34;
    localparam int ZW         = 26;
    localparam int AW         = 24;
    localparam int NW         = MW + AXIS_FRAC + INT_FRAC + 1;
    localparam int QW         = AXIS_FRAC + 1;
    localparam int OW         = 16;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } in_item_t;

    typedef struct packed {
        logic        [OW-1:0] angle_deg;
        logic signed [OW-1:0] axis_x;
        logic signed [OW-1:0] axis_y;
        logic signed [OW-1:0] axis_z;
    } out_item_t;

    typedef struct packed {
        logic          s_zero;
        logic          dy_neg;
        logic          dy_zero;
        logic          dx_neg;
        logic          dz_neg;
        logic [MW-1:0] mag_dx;
        logic [MW-1:0] mag_dy;
        logic [MW-1:0] mag_dz;
    } side_t;

    typedef struct packed {
        side_t           side;
        logic [SW-1:0]   rad;
        logic [REMW-1:0] rem;
        logic [RW-1:0]   root;
    } sq_t;

    typedef struct packed {
        side_t                side;
        logic [RW-1:0]        hs;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [NW-1:0]        nx;
        logic [NW-1:0]        nz;
        logic [QW-1:0]        qx;
        logic [QW-1:0]        qz;
    } rot_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/avafd_front.sv =====
// Front stages: coordinate differences, magnitudes, X and Z squares, their sum.
// Depends on avafd_pkg.
`default_nettype none
module avafd_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire avafd_pkg::in_item_t  in_data,
    output logic                      out_valid,
    output avafd_pkg::sq_t            out_data
);

    logic                                v1_reg, v2_reg, v3_reg;
    logic signed [avafd_pkg::DW-1:0]     dx_reg, dy_reg, dz_reg;
    logic signed [avafd_pkg::DW-1:0]     dx_next, dy_next, dz_next;
    avafd_pkg::side_t                    side2_reg, side2_next;
    logic [avafd_pkg::PW-1:0]            sqx_reg, sqz_reg;
    avafd_pkg::sq_t                      s3_reg, s3_next;
    logic [avafd_pkg::DW-1:0]            ax, ay, az;

    always_comb begin
        dx_next = avafd_pkg::DW'(in_data.end_x) - avafd_pkg::DW'(in_data.start_x);
        dy_next = avafd_pkg::DW'(in_data.end_y) - avafd_pkg::DW'(in_data.start_y);
        dz_next = avafd_pkg::DW'(in_data.end_z) - avafd_pkg::DW'(in_data.start_z);
    end

    always_comb begin
        ax = dx_reg[avafd_pkg::DW-1] ? -dx_reg : dx_reg;
        ay = dy_reg[avafd_pkg::DW-1] ? -dy_reg : dy_reg;
        az = dz_reg[avafd_pkg::DW-1] ? -dz_reg : dz_reg;
        side2_next.mag_dx  = ax[avafd_pkg::MW-1:0];
        side2_next.mag_dy  = ay[avafd_pkg::MW-1:0];
        side2_next.mag_dz  = az[avafd_pkg::MW-1:0];
        side2_next.dx_neg  = dx_reg[avafd_pkg::DW-1];
        side2_next.dy_neg  = dy_reg[avafd_pkg::DW-1];
        side2_next.dz_neg  = dz_reg[avafd_pkg::DW-1];
        side2_next.dy_zero = (dy_reg == '0);
        side2_next.s_zero  = (dx_reg == '0) && (dz_reg == '0);
    end

    always_comb begin
        s3_next.side = side2_reg;
        s3_next.rad  = avafd_pkg::SW'(sqx_reg) + avafd_pkg::SW'(sqz_reg);
        s3_next.rem  = '0;
        s3_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dz_reg    <= dz_next;
            side2_reg <= side2_next;
            sqx_reg   <= side2_next.mag_dx * side2_next.mag_dx;
            sqz_reg   <= side2_next.mag_dz * side2_next.mag_dz;
            s3_reg    <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule
`default_nettype wire

// ===== rtl/avafd_sqrt_step.sv =====
// One stage of the digit-by-digit square root: two radicand bits, one root bit.
// Depends on avafd_pkg.
`default_nettype none
module avafd_sqrt_step (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire avafd_pkg::sq_t  in_data,
    output logic                 out_valid,
    output avafd_pkg::sq_t       out_data
);

    logic                          v_reg;
    avafd_pkg::sq_t                d_reg, d_next;
    logic [avafd_pkg::REMW-1:0]    rem_t, trial;

    always_comb begin
        rem_t  = {in_data.rem[avafd_pkg::REMW-3:0],
                  in_data.rad[avafd_pkg::SW-1:avafd_pkg::SW-2]};
        trial  = {{(avafd_pkg::REMW-avafd_pkg::RW-2){1'b0}}, in_data.root, 2'b01};
        d_next      = in_data;
        d_next.rad  = {in_data.rad[avafd_pkg::SW-3:0], 2'b00};
        if (rem_t >= trial) begin
            d_next.rem  = rem_t - trial;
            d_next.root = {in_data.root[avafd_pkg::RW-2:0], 1'b1};
        end else begin
            d_next.rem  = rem_t;
            d_next.root = {in_data.root[avafd_pkg::RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule
`default_nettype wire

// ===== rtl/avafd_rot_step.sv =====
// One CORDIC vectoring step, plus one quotient bit of both axis dividers when STEP < QW.
// Depends on avafd_pkg.
`default_nettype none
module avafd_rot_step #(
    parameter int STEP = 0
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire avafd_pkg::rot_t  in_data,
    output logic                  out_valid,
    output avafd_pkg::rot_t       out_data
);

    logic                                v_reg;
    avafd_pkg::rot_t                     d_reg, d_next;
    logic signed [avafd_pkg::XW-1:0]     xs, ys;
    logic [avafd_pkg::NW-1:0]            nx_n, nz_n;
    logic [avafd_pkg::QW-1:0]            qx_n, qz_n;

    generate
        if (STEP < avafd_pkg::QW) begin : g_div
            localparam int K = avafd_pkg::QW - 1 - STEP;
            logic [avafd_pkg::NW-1:0] dsh;
            always_comb begin
                dsh = avafd_pkg::NW'(in_data.hs) << K;
                if (in_data.nx >= dsh) begin
                    nx_n = in_data.nx - dsh;
                    qx_n = {in_data.qx[avafd_pkg::QW-2:0], 1'b1};
                end else begin
                    nx_n = in_data.nx;
                    qx_n = {in_data.qx[avafd_pkg::QW-2:0], 1'b0};
                end
                if (in_data.nz >= dsh) begin
                    nz_n = in_data.nz - dsh;
                    qz_n = {in_data.qz[avafd_pkg::QW-2:0], 1'b1};
                end else begin
                    nz_n = in_data.nz;
                    qz_n = {in_data.qz[avafd_pkg::QW-2:0], 1'b0};
                end
            end
        end else begin : g_nodiv
            always_comb begin
                nx_n = in_data.nx;
                nz_n = in_data.nz;
                qx_n = in_data.qx;
                qz_n = in_data.qz;
            end
        end
    endgenerate

    always_comb begin
        xs     = in_data.x >>> STEP;
        ys     = in_data.y >>> STEP;
        d_next = in_data;
        if (in_data.y > 0) begin
            d_next.x = in_data.x + ys;
            d_next.y = in_data.y - xs;
            d_next.z = in_data.z + avafd_pkg::atan_tab(STEP);
        end else if (in_data.y < 0) begin
            d_next.x = in_data.x - ys;
            d_next.y = in_data.y + xs;
            d_next.z = in_data.z - avafd_pkg::atan_tab(STEP);
        end
        d_next.nx = nx_n;
        d_next.nz = nz_n;
        d_next.qx = qx_n;
        d_next.qz = qz_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule
`default_nettype wire

// ===== rtl/avafd_back.sv =====
// Result stage: angle clamp, fold and rounding, axis saturation and signs,
// special directions. Holds the output register. Depends on avafd_pkg.
`default_nettype none
module avafd_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire avafd_pkg::rot_t  in_data,
    output logic                  out_valid,
    output avafd_pkg::out_item_t  out_data
);

    localparam logic [avafd_pkg::AW-1:0] DEG90  = avafd_pkg::AW'(90 << avafd_pkg::TAB_FRAC);
    localparam logic [avafd_pkg::AW-1:0] DEG180 = avafd_pkg::AW'(180 << avafd_pkg::TAB_FRAC);
    localparam logic [avafd_pkg::QW-1:0] ONE    = avafd_pkg::QW'(1 << avafd_pkg::AXIS_FRAC);
    localparam int SH = avafd_pkg::TAB_FRAC - avafd_pkg::ANGLE_FRAC;

    logic                         v_reg;
    avafd_pkg::out_item_t         d_reg, d_next;
    logic [avafd_pkg::AW-1:0]     zc, ang;
    logic [avafd_pkg::AW:0]       ang_r;
    logic [avafd_pkg::QW-1:0]     qx, qz;
    logic [avafd_pkg::OW-1:0]     qx_w, qz_w;

    always_comb begin
        if (in_data.z < 0) begin
            zc = '0;
        end else if (avafd_pkg::AW'(in_data.z) > DEG90) begin
            zc = DEG90;
        end else begin
            zc = avafd_pkg::AW'(in_data.z);
        end
        qx   = (in_data.qx > ONE) ? ONE : in_data.qx;
        qz   = (in_data.qz > ONE) ? ONE : in_data.qz;
        qx_w = avafd_pkg::OW'(qx);
        qz_w = avafd_pkg::OW'(qz);
        if (in_data.side.s_zero) begin
            ang = (in_data.side.dy_neg) ? DEG180 : '0;
        end else begin
            ang = (in_data.side.dy_neg) ? DEG180 - zc : zc;
        end
        ang_r = {1'b0, ang} + (avafd_pkg::AW+1)'(1 << (SH - 1));
        d_next.angle_deg = ang_r[SH +: avafd_pkg::OW];
        if (in_data.side.s_zero) begin
            d_next.axis_x = in_data.side.dy_zero ? '0 : avafd_pkg::OW'(ONE);
            d_next.axis_y = in_data.side.dy_zero ? avafd_pkg::OW'(ONE) : '0;
            d_next.axis_z = '0;
        end else begin
            d_next.axis_x = in_data.side.dz_neg ? -qx_w : qx_w;
            d_next.axis_y = '0;
            d_next.axis_z = in_data.side.dx_neg ? qz_w : -qz_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule
`default_nettype wire

// ===== rtl/axis_angle_from_y_to_direction_unit.sv =====
// Top level of the axis-angle-from-Y block: turns a start and end point into
// the angle from +Y and the unit rotation axis. Depends on avafd_pkg and the
// avafd_front, avafd_sqrt_step, avafd_rot_step and avafd_back modules.
//
// One item enters per clock unless the output stalls. Each passes three front
// stages, 31 square root stages (one root bit each), one preparation stage,
// 23 CORDIC stages that also produce the 15 quotient bits of the two axis
// dividers, and the output register. The whole pipeline advances together
// whenever the output register is empty or its item is being taken.
`default_nettype none
module axis_angle_from_y_to_direction_unit (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire avafd_pkg::in_item_t   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output avafd_pkg::out_item_t       m_data
);

    localparam int NSQ  = avafd_pkg::SQ_STEPS;
    localparam int NROT = avafd_pkg::ROT_STEPS;

    logic             en;
    logic             sq_v   [0:NSQ];
    avafd_pkg::sq_t   sq_d   [0:NSQ];
    logic             rot_v  [0:NROT];
    avafd_pkg::rot_t  rot_d  [0:NROT];
    logic             prep_v_reg;
    avafd_pkg::rot_t  prep_reg, prep_next;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    avafd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (sq_v[0]),
        .out_data  (sq_d[0])
    );

    generate
        for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
            avafd_sqrt_step u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (sq_v[k]),
                .in_data   (sq_d[k]),
                .out_valid (sq_v[k+1]),
                .out_data  (sq_d[k+1])
            );
        end
    endgenerate

    always_comb begin
        prep_next.side = sq_d[NSQ].side;
        prep_next.hs   = sq_d[NSQ].root;
        prep_next.x    = avafd_pkg::XW'({sq_d[NSQ].side.mag_dy,
                                         {avafd_pkg::INT_FRAC{1'b0}}});
        prep_next.y    = avafd_pkg::XW'(sq_d[NSQ].root);
        prep_next.z    = '0;
        prep_next.nx   = avafd_pkg::NW'({sq_d[NSQ].side.mag_dz,
                             {(avafd_pkg::AXIS_FRAC + avafd_pkg::INT_FRAC){1'b0}}})
                         + avafd_pkg::NW'(sq_d[NSQ].root >> 1);
        prep_next.nz   = avafd_pkg::NW'({sq_d[NSQ].side.mag_dx,
                             {(avafd_pkg::AXIS_FRAC + avafd_pkg::INT_FRAC){1'b0}}})
                         + avafd_pkg::NW'(sq_d[NSQ].root >> 1);
        prep_next.qx   = '0;
        prep_next.qz   = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_v_reg <= 1'b0;
        end else if (en) begin
            prep_v_reg <= sq_v[NSQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_reg <= prep_next;
        end
    end

    assign rot_v[0] = prep_v_reg;
    assign rot_d[0] = prep_reg;

    generate
        for (genvar i = 0; i < NROT; i++) begin : g_rot
            avafd_rot_step #(.STEP(i)) u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (rot_v[i]),
                .in_data   (rot_d[i]),
                .out_valid (rot_v[i+1]),
                .out_data  (rot_d[i+1])
            );
        end
    endgenerate

    avafd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rot_v[NROT]),
        .in_data   (rot_d[NROT]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.angle_deg <= 16'd46080)
        else $error("Angle beyond 180 degrees.");

    a_axis_y_zero_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.axis_y != 16'sd0) |->
            (m_data.angle_deg == 16'd0) && (m_data.axis_x == 16'sd0)
            && (m_data.axis_z == 16'sd0))
        else $error("Axis Y set for a non-zero direction.");

    a_axis_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.axis_x <= 16'sd16384) && (m_data.axis_x >= -16'sd16384)
            && (m_data.axis_z <= 16'sd16384) && (m_data.axis_z >= -16'sd16384))
        else $error("Axis component beyond unit length.");

endmodule
`default_nettype wire
